>>> hdl/wgm_pkg.sv
// shared types and constants of the wildcard glob matcher
package wgm_pkg;

  localparam logic       CMD_PATTERN = 1'b0;
  localparam logic       CMD_SUBJECT = 1'b1;
  localparam logic [7:0] STAR_CH     = 8'h2A;
  localparam logic [7:0] ANY_CH      = 8'h3F;
  localparam logic [7:0] NUL_CH      = 8'h00;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    logic       last;
  } wgm_item_t;

  typedef struct packed {
    logic match;
    logic overflow;
  } wgm_result_t;

  // kick from the top level to the walk engine
  typedef struct packed {
    logic go;
    logic ovf;
  } wgm_walk_req_t;

  // status and result back from the walk engine
  typedef struct packed {
    logic        busy;
    logic        done;
    wgm_result_t res;
  } wgm_walk_rsp_t;

endpackage

>>> hdl/wgm_store.sv
// pattern and subject memories with their length and overflow bookkeeping
module wgm_store #(
  parameter int MAX_LEN = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  wgm_pkg::wgm_item_t            item,
  input  logic                          subj_clear,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_LEN+2)-1:0]  rd_w,
  input  logic [$clog2(MAX_LEN+2)-1:0]  rd_s,
  output logic [7:0]                    p_data,
  output logic [7:0]                    s_data,
  output logic [$clog2(MAX_LEN+1)-1:0]  plen,
  output logic [$clog2(MAX_LEN+1)-1:0]  slen,
  output logic                          ovf_now
);
  import wgm_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN+1);

  logic [7:0] pmem [MAX_LEN];
  logic [7:0] smem [MAX_LEN];

  logic          pattern_done;
  logic          overflow_seen;
  logic          subject_over;
  logic [LW-1:0] plen_base;
  logic          oseen_base;
  logic          has_ch;
  logic          p_full;
  logic          s_full;
  logic          p_wr;
  logic          s_wr;

  // a new pattern restarts from an empty store
  assign plen_base  = pattern_done ? '0 : plen;
  assign oseen_base = pattern_done ? 1'b0 : overflow_seen;
  assign has_ch     = (item.ch != NUL_CH);
  assign p_full     = (plen_base == LW'(MAX_LEN));
  assign s_full     = (slen == LW'(MAX_LEN));
  assign p_wr       = load && (item.cmd == CMD_PATTERN) && has_ch && !p_full;
  assign s_wr       = load && (item.cmd == CMD_SUBJECT) && has_ch && !s_full;

  assign ovf_now = overflow_seen || subject_over || (has_ch && s_full);

  always_ff @(posedge clk) begin
    if (p_wr) begin
      pmem[plen_base[AW-1:0]] <= item.ch;
    end
    if (s_wr) begin
      smem[slen[AW-1:0]] <= item.ch;
    end
    if (rd_en) begin
      p_data <= pmem[rd_w[AW-1:0]];
      s_data <= smem[rd_s[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen          <= '0;
      slen          <= '0;
      pattern_done  <= 1'b1;
      overflow_seen <= 1'b0;
      subject_over  <= 1'b0;
    end else if (subj_clear) begin
      slen         <= '0;
      subject_over <= 1'b0;
    end else if (load && (item.cmd == CMD_PATTERN)) begin
      plen          <= p_wr ? plen_base + LW'(1) : plen_base;
      overflow_seen <= oseen_base || (has_ch && p_full);
      pattern_done  <= item.last;
    end else if (load) begin
      if (s_wr) begin
        slen <= slen + LW'(1);
      end
      if (has_ch && s_full) begin
        subject_over <= 1'b1;
      end
    end
  end

endmodule

>>> hdl/wgm_walker.sv
// greedy star-backtrack walk over the stored pattern and subject
module wgm_walker #(
  parameter int MAX_LEN = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wgm_pkg::wgm_walk_req_t        req,
  input  logic [7:0]                    p_data,
  input  logic [7:0]                    s_data,
  input  logic [$clog2(MAX_LEN+1)-1:0]  plen,
  input  logic [$clog2(MAX_LEN+1)-1:0]  slen,
  output logic                          rd_en,
  output logic [$clog2(MAX_LEN+2)-1:0]  rd_w,
  output logic [$clog2(MAX_LEN+2)-1:0]  rd_s,
  output wgm_pkg::wgm_walk_rsp_t        rsp
);
  import wgm_pkg::*;

  localparam int CW = $clog2(MAX_LEN+2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EV   = 4'b0100,
    ST_FIN  = 4'b1000
  } wgm_state_t;

  wgm_state_t state;
  wgm_state_t state_next;
  logic [CW-1:0] w, w_next;
  logic [CW-1:0] s, s_next;
  logic [CW-1:0] mark, mark_next;
  logic [CW-1:0] resume, resume_next;
  logic          star, star_next;
  logic          match, match_next;
  logic          ovf, ovf_next;

  logic [CW-1:0] pl;
  logic [CW-1:0] sl;
  logic          w_lt;
  logic          s_lt;
  logic          is_star;
  logic          hit;

  assign pl      = CW'(plen);
  assign sl      = CW'(slen);
  assign w_lt    = (w < pl);
  assign s_lt    = (s < sl);
  assign is_star = w_lt && (p_data == STAR_CH);
  assign hit     = w_lt && ((p_data == s_data) || (p_data == ANY_CH));

  assign rd_en = (state == ST_RD);
  assign rd_w  = w;
  assign rd_s  = s;

  assign rsp.busy         = (state != ST_IDLE);
  assign rsp.done         = (state == ST_FIN);
  assign rsp.res.match    = match;
  assign rsp.res.overflow = ovf;

  always_comb begin
    state_next  = state;
    w_next      = w;
    s_next      = s;
    mark_next   = mark;
    resume_next = resume;
    star_next   = star;
    match_next  = match;
    ovf_next    = ovf;
    unique case (state)
      ST_IDLE: begin
        if (req.go) begin
          w_next      = '0;
          s_next      = '0;
          mark_next   = '0;
          resume_next = '0;
          star_next   = 1'b0;
          ovf_next    = req.ovf;
          match_next  = 1'b0;
          state_next  = req.ovf ? ST_FIN : ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_EV;
      end
      ST_EV: begin
        state_next = ST_RD;
        if (s_lt) begin
          if (is_star) begin
            // star at the pattern's end swallows the rest
            if (w + CW'(1) >= pl) begin
              match_next = 1'b1;
              state_next = ST_FIN;
            end else begin
              w_next      = w + CW'(1);
              mark_next   = w + CW'(1);
              resume_next = s + CW'(1);
              star_next   = 1'b1;
            end
          end else if (hit) begin
            w_next = w + CW'(1);
            s_next = s + CW'(1);
          end else if (!star) begin
            // mismatch in the literal prefix
            match_next = 1'b0;
            state_next = ST_FIN;
          end else begin
            w_next      = mark;
            s_next      = resume;
            resume_next = resume + CW'(1);
          end
        end else if (is_star) begin
          // subject used up: only trailing stars may remain
          w_next = w + CW'(1);
        end else begin
          match_next = !w_lt;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    w      <= w_next;
    s      <= s_next;
    mark   <= mark_next;
    resume <= resume_next;
    star   <= star_next;
    match  <= match_next;
    ovf    <= ovf_next;
  end

endmodule

>>> hdl/wildcard_glob_matcher_unit.sv
// top level of the wildcard glob matcher
//
// usage: drive item {cmd, ch, last} with start; the transfer happens at a
// clock edge where start is high and busy is low. cmd = 0 loads a pattern
// byte, cmd = 1 a subject byte; ch = 0 stores nothing but last still counts.
// the first pattern byte after a finished pattern starts a new pattern.
// bytes can be loaded back to back, busy stays low between bytes.
// the subject byte with last set starts the walk and raises busy. each walk
// step is a synchronous read of both memories at the current pattern and
// subject positions, then an evaluation of the data read and a step.
// the number of steps depends on the data: without backtracking at most
// pattern length plus subject length plus one, up to about their product
// with backtracking. an overflowed string skips the walk entirely.
// the result appears for one cycle with done, in the cycle after the last
// step (in the cycle right after the transfer on overflow); busy stays
// high through that cycle, then drops. the receiver cannot stall the result.
// reset empties both strings and clears the flags; the memories need no
// clearing pass since only entries below the stored lengths are read.
module wildcard_glob_matcher_unit #(
  parameter int MAX_LEN = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  wgm_pkg::wgm_item_t   item,
  output logic                 done,
  output wgm_pkg::wgm_result_t result
);
  import wgm_pkg::*;

  localparam int CW = $clog2(MAX_LEN+2);
  localparam int LW = $clog2(MAX_LEN+1);

  logic          load;
  logic          ovf_now;
  logic          rd_en;
  logic [CW-1:0] rd_w;
  logic [CW-1:0] rd_s;
  logic [7:0]    p_data;
  logic [7:0]    s_data;
  logic [LW-1:0] plen;
  logic [LW-1:0] slen;
  wgm_walk_req_t req;
  wgm_walk_rsp_t rsp;

  // input transfer
  assign load = start && !busy;

  // the final subject byte kicks the walk; its own overflow counts too
  assign req.go  = load && (item.cmd == CMD_SUBJECT) && item.last;
  assign req.ovf = ovf_now;

  assign busy   = rsp.busy;
  assign done   = rsp.done;
  assign result = rsp.res;

  // subject store is emptied as the result leaves; busy keeps loads away
  wgm_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .item       (item),
    .subj_clear (rsp.done),
    .rd_en      (rd_en),
    .rd_w       (rd_w),
    .rd_s       (rd_s),
    .p_data     (p_data),
    .s_data     (s_data),
    .plen       (plen),
    .slen       (slen),
    .ovf_now    (ovf_now)
  );

  wgm_walker #(
    .MAX_LEN (MAX_LEN)
  ) u_walker (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .p_data (p_data),
    .s_data (s_data),
    .plen   (plen),
    .slen   (slen),
    .rd_en  (rd_en),
    .rd_w   (rd_w),
    .rd_s   (rd_s),
    .rsp    (rsp)
  );

endmodule

>>> hdl/wgm_checker.sv
// port-level checks of the wildcard glob matcher and their binding
module wgm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input wgm_pkg::wgm_item_t   item,
  input logic                 done,
  input wgm_pkg::wgm_result_t result
);
  import wgm_pkg::*;

  // final subject byte always starts a busy walk
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_SUBJECT && item.last) |=> busy)
    else $error("walk did not raise busy");

  // result cycle is covered by busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while not busy");

  // one strobe per result
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // overflow forces no match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |-> !result.match)
    else $error("match reported with overflow");

  // pattern bytes never cause a result
  a_pat_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_PATTERN) |=> !done)
    else $error("result after a pattern byte");

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

>>> tb/testbench.sv
// self-checking testbench of the wildcard glob matcher
module testbench;
  import wgm_pkg::*;

  localparam int MAX_LEN    = 256;
  // cycles without any transfer or result before the run is declared hung;
  // set well above the slowest walk (full stores, heavy backtracking)
  localparam int HANG_LIMIT = 400000;
  // cycles to let pass once nothing is expected any more
  localparam int SETTLE     = 8;

  localparam wgm_result_t HIT  = '{1'b1, 1'b0};
  localparam wgm_result_t MISS = '{1'b0, 1'b0};
  localparam wgm_result_t OVF  = '{1'b0, 1'b1};
  localparam wgm_result_t NONE = '{1'b0, 1'b0};

  // one row of the directed table: text bytes (high byte first, zero bytes
  // skipped), then fill_n copies of fill_ch; close puts last on the final item
  typedef struct packed {
    logic        cmd;
    logic [63:0] text;
    logic [9:0]  fill_n;
    logic [7:0]  fill_ch;
    logic        close;
    logic        typed;
    wgm_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  wgm_item_t   item  = '0;
  logic        busy;
  logic        done;
  wgm_result_t result;

  wildcard_glob_matcher_unit #(
    .MAX_LEN (MAX_LEN)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // private copy of the matcher state
  logic [7:0] pat_mem [MAX_LEN];
  int         pat_len    = 0;
  logic [7:0] subj_mem [MAX_LEN];
  int         subj_len   = 0;
  bit         pat_closed = 1'b1;
  bit         pat_ovf    = 1'b0;
  bit         subj_ovf   = 1'b0;

  // results still owed by the block, oldest first
  wgm_result_t verdicts_due[$];

  // a typed-in expectation that overrides the computed one for a table row
  bit          typed_on  = 1'b0;
  wgm_result_t typed_exp = NONE;

  int items_sent   = 0;
  int results_seen = 0;
  int hits_seen    = 0;
  int ovfs_seen    = 0;
  int fails        = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;

  // scratch strings for the random part
  logic [7:0] pat_buf[$];
  logic [7:0] subj_buf[$];

  // greedy walk with a single remembered star, as the block does it
  function automatic logic glob_hit();
    int w, s, mark, resume;
    w = 0;
    s = 0;
    mark = 0;
    resume = 0;
    // literal prefix up to the first star
    while (s < subj_len && (w >= pat_len || pat_mem[w] != STAR_CH)) begin
      if (w >= pat_len) return 1'b0;
      if (pat_mem[w] != subj_mem[s] && pat_mem[w] != ANY_CH) return 1'b0;
      w++;
      s++;
    end
    while (s < subj_len) begin
      if (w < pat_len && pat_mem[w] == STAR_CH) begin
        w++;
        if (w >= pat_len) return 1'b1;
        mark = w;
        resume = s + 1;
      end else if (w < pat_len && (pat_mem[w] == subj_mem[s] || pat_mem[w] == ANY_CH)) begin
        w++;
        s++;
      end else begin
        // mismatch: retry after the last star, one subject byte further on
        w = mark;
        s = resume;
        resume++;
      end
    end
    // trailing stars match the empty rest
    while (w < pat_len && pat_mem[w] == STAR_CH) w++;
    return (w >= pat_len);
  endfunction

  // update the private state for one accepted item, queue its verdict
  task automatic absorb_item(input wgm_item_t it);
    wgm_result_t v;
    if (it.cmd == CMD_PATTERN) begin
      // first byte after a finished pattern starts a new one
      if (pat_closed) begin
        pat_len    = 0;
        pat_ovf    = 1'b0;
        pat_closed = 1'b0;
      end
      if (it.ch != NUL_CH) begin
        if (pat_len < MAX_LEN) begin
          pat_mem[pat_len] = it.ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      if (it.last) pat_closed = 1'b1;
    end else begin
      if (it.ch != NUL_CH) begin
        if (subj_len < MAX_LEN) begin
          subj_mem[subj_len] = it.ch;
          subj_len++;
        end else begin
          subj_ovf = 1'b1;
        end
      end
      if (it.last) begin
        v.overflow = pat_ovf | subj_ovf;
        v.match    = v.overflow ? 1'b0 : glob_hit();
        verdicts_due.push_back(typed_on ? typed_exp : v);
        subj_len = 0;
        subj_ovf = 1'b0;
      end
    end
  endtask

  // monitor: everything sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (done) begin
        results_seen++;
        if (result.match) hits_seen++;
        if (result.overflow) ovfs_seen++;
        if (verdicts_due.size() == 0) begin
          $error("result with nothing expected: match %0b, overflow %0b",
                 result.match, result.overflow);
          fails++;
        end else begin
          if (result.match !== verdicts_due[0].match) begin
            $error("match: expected %0b, actual %0b", verdicts_due[0].match, result.match);
            fails++;
          end
          if (result.overflow !== verdicts_due[0].overflow) begin
            $error("overflow: expected %0b, actual %0b",
                   verdicts_due[0].overflow, result.overflow);
            fails++;
          end
          void'(verdicts_due.pop_front());
        end
      end
      // input transfer
      if (start && !busy) begin
        absorb_item(item);
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // random gap between bursts of back-to-back items; junk on item meanwhile
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        item  <= 10'($urandom);
      end
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // present one item at the falling edge, hold it until the transfer
  task automatic drive_item(input wgm_item_t it, input bit tv, input wgm_result_t tr);
    @(negedge clk);
    item      <= it;
    start     <= 1'b1;
    typed_on  = tv;
    typed_exp = tr;
    do @(posedge clk); while (busy);
    items_sent++;
    sender_gap();
  endtask

  // send a string; an empty closed string is a single zero byte with last;
  // noisy slips in stray zero bytes, which store nothing
  task automatic send_str(input logic cmd, input logic [7:0] s[$], input bit close,
                          input bit noisy, input bit tv, input wgm_result_t tr);
    int i;
    if (s.size() == 0) begin
      if (close) drive_item('{cmd, NUL_CH, 1'b1}, tv, tr);
    end else begin
      for (i = 0; i < s.size(); i++) begin
        if (noisy && $urandom_range(0, 19) == 0) drive_item('{cmd, NUL_CH, 1'b0}, 1'b0, NONE);
        drive_item('{cmd, s[i], close && (i == s.size() - 1)}, tv, tr);
      end
    end
  endtask

  // hold the sender until every owed result is in, then let the block settle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // directed part: empty strings, case, zero bytes, full and overfull stores,
  // subjects against an unfinished pattern
  task automatic run_table();
    stim_row_t  rows [24];
    logic [7:0] s[$];
    int         r, b;
    rows[0]  = '{CMD_SUBJECT, "",       10'd0,   NUL_CH, 1'b1, 1'b1, HIT};  // empty vs empty
    rows[1]  = '{CMD_SUBJECT, "a",      10'd0,   NUL_CH, 1'b1, 1'b1, MISS};
    rows[2]  = '{CMD_PATTERN, "a*b?c",  10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    rows[3]  = '{CMD_SUBJECT, "axxbyc", 10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    rows[4]  = '{CMD_SUBJECT, "ab",     10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    rows[5]  = '{CMD_SUBJECT, "AXBYC",  10'd0,   NUL_CH, 1'b1, 1'b0, NONE};  // case counts
    rows[6]  = '{CMD_PATTERN, "*",      10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    rows[7]  = '{CMD_SUBJECT, "",       10'd0,   NUL_CH, 1'b1, 1'b1, HIT};
    rows[8]  = '{CMD_SUBJECT, "",       10'd3,   8'hFF,  1'b1, 1'b1, HIT};
    rows[9]  = '{CMD_PATTERN, "?*",     10'd2,   NUL_CH, 1'b1, 1'b0, NONE};  // last on zero byte
    rows[10] = '{CMD_SUBJECT, "",       10'd1,   8'h01,  1'b1, 1'b0, NONE};
    rows[11] = '{CMD_PATTERN, "ab",     10'd0,   NUL_CH, 1'b0, 1'b0, NONE};  // left open
    rows[12] = '{CMD_SUBJECT, "ab",     10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    rows[13] = '{CMD_PATTERN, "c",      10'd0,   NUL_CH, 1'b1, 1'b0, NONE};  // extends to abc
    rows[14] = '{CMD_SUBJECT, "abc",    10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    rows[15] = '{CMD_PATTERN, "",       10'd256, "x",    1'b1, 1'b0, NONE};  // store exactly full
    rows[16] = '{CMD_SUBJECT, "",       10'd256, "x",    1'b1, 1'b1, HIT};
    rows[17] = '{CMD_SUBJECT, "",       10'd257, "x",    1'b1, 1'b1, OVF};
    rows[18] = '{CMD_SUBJECT, "x",      10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    rows[19] = '{CMD_PATTERN, "",       10'd257, "*",    1'b1, 1'b0, NONE};  // pattern overflow
    rows[20] = '{CMD_SUBJECT, "abc",    10'd0,   NUL_CH, 1'b1, 1'b1, OVF};
    rows[21] = '{CMD_PATTERN, "",       10'd0,   NUL_CH, 1'b1, 1'b0, NONE};  // new pattern clears it
    rows[22] = '{CMD_SUBJECT, "",       10'd0,   NUL_CH, 1'b1, 1'b1, HIT};
    rows[23] = '{CMD_PATTERN, "*a*?",   10'd0,   NUL_CH, 1'b1, 1'b0, NONE};
    for (r = 0; r < 24; r++) begin
      s.delete();
      for (b = 7; b >= 0; b--)
        if (rows[r].text[b*8 +: 8] != NUL_CH) s.push_back(rows[r].text[b*8 +: 8]);
      repeat (rows[r].fill_n) s.push_back(rows[r].fill_ch);
      send_str(rows[r].cmd, s, rows[r].close, 1'b0, rows[r].typed, rows[r].want);
    end
    s = '{"b", "a", "b"};
    send_str(CMD_SUBJECT, s, 1'b1, 1'b0, 1'b0, NONE);
  endtask

  // a short alphabet so that matches happen, a few upper-case letters
  function automatic logic [7:0] letter();
    if ($urandom_range(0, 9) == 0) return 8'("A" + $urandom_range(0, 2));
    return 8'("a" + $urandom_range(0, 2));
  endfunction

  // pattern character: wildcards, letters, now and then any nonzero byte
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return STAR_CH;
    if (r < 27) return ANY_CH;
    if (r < 90) return letter();
    return 8'($urandom_range(1, 255));
  endfunction

  // subject mostly built to fit the pattern, sometimes spoiled, else random
  task automatic make_subject();
    int i;
    subj_buf.delete();
    if ($urandom_range(0, 9) < 6) begin
      for (i = 0; i < pat_buf.size(); i++) begin
        if (pat_buf[i] == STAR_CH) repeat ($urandom_range(0, 3)) subj_buf.push_back(letter());
        else if (pat_buf[i] == ANY_CH) subj_buf.push_back(letter());
        else subj_buf.push_back(pat_buf[i]);
      end
      if (subj_buf.size() > 0 && $urandom_range(0, 2) == 0)
        subj_buf[$urandom_range(0, subj_buf.size() - 1)] = letter();
      else if ($urandom_range(0, 5) == 0)
        subj_buf.push_back(letter());
    end else begin
      repeat ($urandom_range(0, 12)) subj_buf.push_back(pick_char());
    end
  endtask

  // one pattern, then a few subjects against it, with some noise
  task automatic random_round();
    logic [7:0] head[$];
    logic [7:0] tail[$];
    int         kind, n, i, cut;
    kind = $urandom_range(0, 99);
    pat_buf.delete();
    if (kind < 2) begin
      // rare long pattern, near or past the store size
      n = $urandom_range(MAX_LEN - 6, MAX_LEN + 6);
      repeat (n) pat_buf.push_back(($urandom_range(0, 15) == 0) ? STAR_CH : 8'("a"));
    end else begin
      repeat ($urandom_range(0, 10)) pat_buf.push_back(pick_char());
    end
    if (kind >= 2 && kind < 12 && pat_buf.size() > 1) begin
      // subject tested against a pattern still being loaded
      cut = $urandom_range(1, pat_buf.size() - 1);
      for (i = 0; i < pat_buf.size(); i++)
        if (i < cut) head.push_back(pat_buf[i]);
        else tail.push_back(pat_buf[i]);
      send_str(CMD_PATTERN, head, 1'b0, 1'b1, 1'b0, NONE);
      make_subject();
      send_str(CMD_SUBJECT, subj_buf, 1'b1, 1'b1, 1'b0, NONE);
      send_str(CMD_PATTERN, tail, 1'b1, 1'b1, 1'b0, NONE);
    end else begin
      send_str(CMD_PATTERN, pat_buf, 1'b1, 1'b1, 1'b0, NONE);
    end
    repeat ((kind < 2) ? 1 : $urandom_range(1, 4)) begin
      make_subject();
      send_str(CMD_SUBJECT, subj_buf, 1'b1, 1'b1, 1'b0, NONE);
    end
    // broken sequences: raw items of any kind
    if (kind >= 90)
      repeat ($urandom_range(1, 6)) drive_item(10'($urandom), 1'b0, NONE);
    if ($urandom_range(0, 19) == 0) drain();
  endtask

  initial begin
    int table_items;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_table();
    table_items = items_sent;
    // sender holds off until every result is in
    drain();

    while (items_sent - table_items < 800) random_round();

    @(negedge clk);
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d input transfers and %0d checked results", items_sent,
             results_seen);
    $display("of those results %0d matched and %0d flagged overflow", hits_seen, ovfs_seen);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
